[sv/mcts_pkg.sv]
// ----------------------------------------------------------------------------
// mcts_pkg
// Shared sizes, item codes and control types of the Markov chain step table.
// ----------------------------------------------------------------------------
package mcts_pkg;

  localparam int NUM_STATES     = 64;
  localparam int NUM_FACES      = 8;
  localparam int MAX_MOVES      = 8;
  localparam int PROB_FRAC_BITS = 32;

  localparam int ROWS    = NUM_STATES * NUM_FACES;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SLOT_W  = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
  localparam int CNT_W   = $clog2(MAX_MOVES + 1);
  localparam int THR_W   = PROB_FRAC_BITS + 1;

  localparam logic [2:0] KIND_THR    = 3'd0;
  localparam logic [2:0] KIND_TARGET = 3'd1;
  localparam logic [2:0] KIND_COUNTS = 3'd2;
  localparam logic [2:0] KIND_SET    = 3'd3;
  localparam logic [2:0] KIND_STEP   = 3'd4;

  localparam logic CFG_LADDER_CONNECTED = 1'b0;
  localparam logic CFG_LADDER_FINE      = 1'b1;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } mcts_cmd_t;

  typedef struct packed {
    logic clear_last;
  } mcts_status_t;

endpackage

[sv/markov_chain_table_step_top.sv]
// ----------------------------------------------------------------------------
// markov_chain_table_step_top
// Markov chain step table: table writes, start state and inverse-CDF steps.
// ----------------------------------------------------------------------------
// For each item, in the accept cycle the row of the current state and die
// face is read from the banked threshold, target and count memories into
// registers, and in the execute state the slot search runs and the result
// is loaded into the output register once that register is free. A new item
// is accepted once the previous result has entered the output register, so
// a stalled output holds off the next item. After reset the block clears all
// 512 rows of the row count memory, one row per cycle, and accepts no item in
// that time; configuration writes are always taken.
module markov_chain_table_step_top
  import mcts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  row_state_i,
  input  logic [2:0]  row_face_i,
  input  logic [2:0]  slot_i,
  input  logic [32:0] threshold_i,
  input  logic [5:0]  target_state_i,
  input  logic [3:0]  threshold_count_i,
  input  logic [3:0]  move_count_i,
  input  logic [5:0]  start_state_i,
  input  logic [2:0]  die_face_i,
  input  logic [31:0] uniform_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  current_state_o,
  output logic        moved_o,
  output logic        error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);

  mcts_cmd_t    cmd;
  mcts_status_t status;

  assign cfg_ready_o = 1'b1;

  mcts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mcts_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .row_state_i       (row_state_i),
    .row_face_i        (row_face_i),
    .slot_i            (slot_i),
    .threshold_i       (threshold_i),
    .target_state_i    (target_state_i),
    .threshold_count_i (threshold_count_i),
    .move_count_i      (move_count_i),
    .start_state_i     (start_state_i),
    .die_face_i        (die_face_i),
    .uniform_i         (uniform_i),
    .current_state_o   (current_state_o),
    .moved_o           (moved_o),
    .error_o           (error_o)
  );

endmodule

[sv/mcts_ctrl.sv]
// ----------------------------------------------------------------------------
// mcts_ctrl
// Sequencer: count table clearing after reset, item accept, evaluate and
// hand-off into the output register.
// ----------------------------------------------------------------------------
module mcts_ctrl
  import mcts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  mcts_status_t status_i,
  output mcts_cmd_t    cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.clear  = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/mcts_dp.sv]
// ----------------------------------------------------------------------------
// mcts_dp
// Datapath: banked threshold and target memories, row count memory, ladder
// flags, chain position and the slot search of a step.
// ----------------------------------------------------------------------------
module mcts_dp
  import mcts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mcts_cmd_t    cmd_i,
  output mcts_status_t status_o,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic         cfg_data_i,
  input  logic [2:0]   kind_i,
  input  logic [5:0]   row_state_i,
  input  logic [2:0]   row_face_i,
  input  logic [2:0]   slot_i,
  input  logic [32:0]  threshold_i,
  input  logic [5:0]   target_state_i,
  input  logic [3:0]   threshold_count_i,
  input  logic [3:0]   move_count_i,
  input  logic [5:0]   start_state_i,
  input  logic [2:0]   die_face_i,
  input  logic [31:0]  uniform_i,
  output logic [5:0]   current_state_o,
  output logic         moved_o,
  output logic         error_o
);

  logic [THR_W-1:0]       thr_rd_q [MAX_MOVES];
  logic [STATE_W-1:0]     tgt_rd_q [MAX_MOVES];
  logic [2*CNT_W-1:0]     cnt_mem [ROWS];
  logic [CNT_W-1:0]       tc_q, mc_q;

  logic [ROW_W:0]         clr_q;
  logic                   lad_conn_q, lad_fine_q;
  logic [STATE_W-1:0]     pos_q;
  logic                   moved_q, error_q;

  logic [2:0]             kind_q;
  logic [PROB_FRAC_BITS-1:0] uni_q;
  logic [5:0]             start_q;
  logic                   face_ok_q;

  logic                   row_ok, addr_ok;
  logic [ROW_W-1:0]       wr_row, rd_row;
  logic [STATE_W-1:0]     tgt_sat;
  logic [CNT_W-1:0]       tc_sat, mc_sat;

  logic [CNT_W-1:0]       sel_idx;
  logic                   found;
  logic                   step_err, step_move;

  assign row_ok  = (int'(row_state_i) < NUM_STATES) && (int'(row_face_i) < NUM_FACES);
  assign addr_ok = row_ok && (int'(slot_i) < MAX_MOVES);
  assign wr_row  = ROW_W'(int'(row_state_i) * NUM_FACES + int'(row_face_i));
  assign rd_row  = ROW_W'(int'(pos_q) * NUM_FACES + int'(die_face_i));

  assign tgt_sat = (int'(target_state_i) >= NUM_STATES) ? STATE_W'(NUM_STATES - 1)
                                                        : STATE_W'(target_state_i);
  assign tc_sat  = (int'(threshold_count_i) > MAX_MOVES) ? CNT_W'(MAX_MOVES)
                                                         : CNT_W'(threshold_count_i);
  assign mc_sat  = (int'(move_count_i) > MAX_MOVES) ? CNT_W'(MAX_MOVES)
                                                    : CNT_W'(move_count_i);

  for (genvar lane = 0; lane < MAX_MOVES; lane++) begin : g_bank
    logic [THR_W-1:0]   thr_mem [ROWS];
    logic [STATE_W-1:0] tgt_mem [ROWS];
    logic               lane_sel;

    assign lane_sel = (int'(slot_i) == lane) && addr_ok && cmd_i.accept;

    always_ff @(posedge clk_i) begin
      if (lane_sel && (kind_i == KIND_THR)) begin
        thr_mem[wr_row] <= THR_W'(threshold_i);
      end
      if (lane_sel && (kind_i == KIND_TARGET)) begin
        tgt_mem[wr_row] <= tgt_sat;
      end
      if (cmd_i.accept) begin
        thr_rd_q[lane] <= thr_mem[rd_row];
        tgt_rd_q[lane] <= tgt_mem[rd_row];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      cnt_mem[clr_q[ROW_W-1:0]] <= '0;
    end else if (cmd_i.accept && (kind_i == KIND_COUNTS) && row_ok) begin
      cnt_mem[wr_row] <= {tc_sat, mc_sat};
    end
    if (cmd_i.accept) begin
      {tc_q, mc_q} <= cnt_mem[rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign status_o.clear_last = (int'(clr_q) == ROWS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lad_conn_q <= 1'b1;
      lad_fine_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LADDER_CONNECTED: lad_conn_q <= cfg_data_i;
        CFG_LADDER_FINE:      lad_fine_q <= cfg_data_i;
        default:              lad_fine_q <= lad_fine_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q    <= kind_i;
      uni_q     <= PROB_FRAC_BITS'(uniform_i);
      start_q   <= start_state_i;
      face_ok_q <= (int'(die_face_i) < NUM_FACES);
    end
  end

  always_comb begin
    sel_idx = tc_q;
    found   = 1'b0;
    for (int l = 0; l < MAX_MOVES; l++) begin
      if (!found && (l < int'(tc_q)) && ({1'b0, uni_q} < thr_rd_q[l])) begin
        sel_idx = CNT_W'(l);
        found   = 1'b1;
      end
    end
  end

  assign step_err  = (kind_q == KIND_STEP) && !(lad_conn_q && lad_fine_q);
  assign step_move = (kind_q == KIND_STEP) && !step_err && face_ok_q &&
                     (tc_q != '0) && (sel_idx < mc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.commit) begin
      if ((kind_q == KIND_SET) && (int'(start_q) < NUM_STATES)) begin
        pos_q <= STATE_W'(start_q);
      end else if (step_move) begin
        pos_q <= tgt_rd_q[sel_idx[SLOT_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      moved_q <= step_move;
      error_q <= step_err;
    end
  end

  assign current_state_o = 6'(pos_q);
  assign moved_o         = moved_q;
  assign error_o         = error_q;

endmodule
